// File: hdl/rgb_to_intensity_tint_saturation_core_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the RGB to intensity/tint/saturation core
// The macros expand to concurrent assertions in simulation and to nothing in
// synthesis. They expect clk and rst_n in scope.
// ----------------------------------------------------------------------------
`ifndef RGB_TO_INTENSITY_TINT_SATURATION_CORE_ASSERT_SVH
`define RGB_TO_INTENSITY_TINT_SATURATION_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define RTITS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define RTITS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define RTITS_ASSERT_IMP(lbl, ante, cons, msg)
`define RTITS_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

// File: hdl/rtits_pkg.sv
// ----------------------------------------------------------------------------
// rtits_pkg
// Shared types, constants and helpers of the intensity/tint/saturation core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rtits_pkg;

  localparam int OUT_FRAC_BITS_DEF = 8;
  localparam int ANGLE_STEPS       = 30;
  // Rotation datapath width; the vector magnitude stays below 2^43.
  localparam int CW                = 45;

  // sqrt(3) in Q32, rounded.
  localparam logic [32:0] SQRT3_Q32 = 33'd7439101574;
  localparam logic [31:0] HALF_TURN = 32'h8000_0000;

  // atan(2^-i) in turns scaled by 2^32.
  localparam logic [31:0] ATAN_TURNS [ANGLE_STEPS] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
    32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
    32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001
  };

  typedef struct packed {
    logic        vld;
    logic        last;
    logic        grey;
    logic        sat_full;
    logic [15:0] intensity;
  } ctl_t;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic [31:0]          z;
  } cor_t;

  function automatic logic [15:0] sat16(input logic [31:0] v);
    return (v > 32'd65535) ? 16'hFFFF : v[15:0];
  endfunction

endpackage

`default_nettype wire

// File: hdl/rtits_if.sv
// ----------------------------------------------------------------------------
// rtits_pix_if / rtits_res_if
// Valid/ready channels for pixels in and converted results out.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface rtits_pix_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic       last_pixel;

  modport source (output valid, output red, output green, output blue,
                  output last_pixel, input ready);
  modport sink   (input valid, input red, input green, input blue,
                  input last_pixel, output ready);
endinterface

interface rtits_res_if;
  logic        valid;
  logic        ready;
  logic [15:0] intensity;
  logic [15:0] tint;
  logic [15:0] saturation;
  logic        last_out;

  modport source (output valid, output intensity, output tint, output saturation,
                  output last_out, input ready);
  modport sink   (input valid, input intensity, input tint, input saturation,
                  input last_out, output ready);
endinterface

`default_nettype wire

// File: hdl/rgb_to_intensity_tint_saturation_core.sv
// ----------------------------------------------------------------------------
// rgb_to_intensity_tint_saturation_core
// Converts a stream of 8-bit RGB pixels into intensity, tint and saturation.
// ----------------------------------------------------------------------------
// The core takes one pixel per clock and returns one result per pixel, in
// order, after the pixel beat is taken and has passed four front stages,
// thirty rotation stages of the tint angle search (which also carry the
// bit-per-stage saturation divider), two finishing stages and the output
// register. Throughput is one beat per cycle while in_pix.ready is high; a two-entry
// output buffer lets the pipeline keep taking beats as the sink stalls, and
// in_pix.ready drops only while that buffer is full.
`timescale 1ns / 1ps
`default_nettype none
`include "rgb_to_intensity_tint_saturation_core_assert.svh"

module rgb_to_intensity_tint_saturation_core
  import rtits_pkg::*;
#(
  parameter int OUT_FRAC_BITS = OUT_FRAC_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  rtits_pix_if.sink    in_pix,
  rtits_res_if.source  out_res
);

  localparam int QW = 8 + OUT_FRAC_BITS;
  localparam int NW = QW + 11;
  localparam int TW = 41 + OUT_FRAC_BITS;
  localparam int FW = 9 + OUT_FRAC_BITS;
  localparam logic [QW-1:0] FULL   = QW'(255 << OUT_FRAC_BITS);
  localparam logic [15:0]   FULL16 = (FULL > 65535) ? 16'hFFFF : 16'(FULL);
  localparam logic [QW-1:0] RND1   = QW'(((2 ** OUT_FRAC_BITS) + 1) / 3);
  localparam logic [QW-1:0] RND2   = QW'(((2 ** (OUT_FRAC_BITS + 1)) + 1) / 3);

  logic en;
  logic skid_vld_r, out_vld_r;

  assign en           = !skid_vld_r;
  assign in_pix.ready = en;

  // Input register.
  logic       p1_vld_r, p1_last_r;
  logic [7:0] p1_red_r, p1_green_r, p1_blue_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_vld_r <= 1'b0;
    end else if (en) begin
      p1_vld_r <= in_pix.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1_red_r   <= in_pix.red;
      p1_green_r <= in_pix.green;
      p1_blue_r  <= in_pix.blue;
      p1_last_r  <= in_pix.last_pixel;
    end
  end

  // Channel sum, deviations from the mean and the projections.
  logic [7:0]         ch [3];
  logic [9:0]         sum_nxt, t3;
  logic [9:0]         dev_nxt [3];
  logic [9:0]         den_nxt [3];
  logic signed [10:0] cx, cxa_nxt;
  logic signed [9:0]  cy, cya_nxt;
  logic               half_nxt;

  always_comb begin
    ch[0]   = p1_red_r;
    ch[1]   = p1_green_r;
    ch[2]   = p1_blue_r;
    sum_nxt = 10'(p1_red_r) + 10'(p1_green_r) + 10'(p1_blue_r);
    t3      = '0;
    for (int i = 0; i < 3; i++) begin
      t3 = 10'({ch[i], 1'b0}) + 10'(ch[i]);
      if (t3 < sum_nxt) begin
        dev_nxt[i] = sum_nxt - t3;
        den_nxt[i] = sum_nxt;
      end else begin
        dev_nxt[i] = t3 - sum_nxt;
        den_nxt[i] = 10'd765 - sum_nxt;
      end
    end
    cx = $signed({2'b00, p1_red_r, 1'b0}) - $signed({3'b000, p1_green_r})
         - $signed({3'b000, p1_blue_r});
    cy = $signed({2'b00, p1_green_r}) - $signed({2'b00, p1_blue_r});
    // Fold the left half plane onto the right one; the angle starts at half a turn.
    half_nxt = cx[10];
    cxa_nxt  = half_nxt ? -cx : cx;
    cya_nxt  = half_nxt ? -cy : cy;
  end

  logic               p2_vld_r, p2_last_r, p2_grey_r, p2_white_r, p2_half_r;
  logic [9:0]         p2_sum_r;
  logic [9:0]         p2_dev_r [3];
  logic [9:0]         p2_den_r [3];
  logic signed [10:0] p2_cx_r;
  logic signed [9:0]  p2_cy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p2_vld_r <= 1'b0;
    end else if (en) begin
      p2_vld_r <= p1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p2_last_r  <= p1_last_r;
      p2_grey_r  <= (p1_red_r == p1_green_r) && (p1_green_r == p1_blue_r);
      p2_white_r <= sum_nxt == 10'd765;
      p2_half_r  <= half_nxt;
      p2_sum_r   <= sum_nxt;
      p2_dev_r   <= dev_nxt;
      p2_den_r   <= den_nxt;
      p2_cx_r    <= cxa_nxt;
      p2_cy_r    <= cya_nxt;
    end
  end

  // Ratio comparisons by cross products, intensity, start vector.
  logic [2:0]         ge_nxt;
  logic [26:0]        div3_prod;
  logic [9:0]         third;
  logic [9:0]         rem3;
  logic [QW-1:0]      inten;
  logic signed [43:0] y_prod;
  cor_t               cor_init;

  always_comb begin
    ge_nxt[0] = (20'(p2_dev_r[0]) * 20'(p2_den_r[1])) >= (20'(p2_dev_r[1]) * 20'(p2_den_r[0]));
    ge_nxt[1] = (20'(p2_dev_r[0]) * 20'(p2_den_r[2])) >= (20'(p2_dev_r[2]) * 20'(p2_den_r[0]));
    ge_nxt[2] = (20'(p2_dev_r[1]) * 20'(p2_den_r[2])) >= (20'(p2_dev_r[2]) * 20'(p2_den_r[1]));

    // sum / 3 by reciprocal; the remainder picks the rounded fraction.
    div3_prod = 27'(p2_sum_r) * 27'(17'd43691);
    third     = div3_prod[26:17];
    rem3      = p2_sum_r - (10'({third, 1'b0}) + third);
    inten     = QW'(third[7:0]) << OUT_FRAC_BITS;
    case (rem3[1:0])
      2'd1:    inten = inten + RND1;
      2'd2:    inten = inten + RND2;
      default: inten = inten;
    endcase

    y_prod     = $signed(p2_cy_r) * $signed({1'b0, SQRT3_Q32});
    cor_init.x = {{(CW-43){p2_cx_r[10]}}, p2_cx_r, 32'd0};
    cor_init.y = CW'(y_prod);
    cor_init.z = p2_half_r ? HALF_TURN : 32'd0;
  end

  logic        p3_vld_r, p3_last_r, p3_grey_r, p3_white_r;
  logic [9:0]  p3_dev_r [3];
  logic [9:0]  p3_den_r [3];
  logic [2:0]  p3_ge_r;
  logic [15:0] p3_int_r;
  cor_t        p3_cor_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p3_vld_r <= 1'b0;
    end else if (en) begin
      p3_vld_r <= p2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p3_last_r  <= p2_last_r;
      p3_grey_r  <= p2_grey_r;
      p3_white_r <= p2_white_r;
      p3_dev_r   <= p2_dev_r;
      p3_den_r   <= p2_den_r;
      p3_ge_r    <= ge_nxt;
      p3_int_r   <= sat16(32'(inten));
      p3_cor_r   <= cor_init;
    end
  end

  // Pick the largest ratio and set up the divider.
  logic [9:0]    dev_s, den_s;
  logic [17:0]   dev255;
  logic [NW-1:0] numer;
  ctl_t          ctl_nxt;

  always_comb begin
    if (p3_ge_r[0] && p3_ge_r[1]) begin
      dev_s = p3_dev_r[0];
      den_s = p3_den_r[0];
    end else if (p3_ge_r[2]) begin
      dev_s = p3_dev_r[1];
      den_s = p3_den_r[1];
    end else begin
      dev_s = p3_dev_r[2];
      den_s = p3_den_r[2];
    end
    dev255 = {dev_s, 8'd0} - 18'(dev_s);
    // Rounded quotient: (2 * dev * full + den) / (2 * den).
    numer  = {dev255, {(OUT_FRAC_BITS + 1){1'b0}}} + NW'(den_s);
    ctl_nxt.vld       = p3_vld_r;
    ctl_nxt.last      = p3_last_r;
    ctl_nxt.grey      = p3_grey_r;
    ctl_nxt.sat_full  = p3_white_r || (dev_s >= den_s);
    ctl_nxt.intensity = p3_int_r;
  end

  ctl_t          st_ctl [ANGLE_STEPS+1];
  cor_t          st_cor [ANGLE_STEPS+1];
  logic [10:0]   st_rem [ANGLE_STEPS+1];
  logic [QW-1:0] st_nq  [ANGLE_STEPS+1];
  logic [10:0]   st_dvs [ANGLE_STEPS+1];
  ctl_t          p4_ctl_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p4_ctl_r.vld <= 1'b0;
    end else if (en) begin
      p4_ctl_r <= ctl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st_cor[0] <= p3_cor_r;
      st_rem[0] <= numer[NW-1:QW];
      st_nq[0]  <= numer[QW-1:0];
      st_dvs[0] <= {den_s, 1'b0};
    end
  end

  assign st_ctl[0] = p4_ctl_r;

  for (genvar g = 0; g < ANGLE_STEPS; g++) begin : g_step
    rtits_step #(
      .OUT_FRAC_BITS (OUT_FRAC_BITS),
      .STEP          (g)
    ) u_step (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .ctl_i (st_ctl[g]),
      .cor_i (st_cor[g]),
      .rem_i (st_rem[g]),
      .nq_i  (st_nq[g]),
      .dvs_i (st_dvs[g]),
      .ctl_o (st_ctl[g+1]),
      .cor_o (st_cor[g+1]),
      .rem_o (st_rem[g+1]),
      .nq_o  (st_nq[g+1]),
      .dvs_o (st_dvs[g+1])
    );
  end

  // Angle times 255.
  ctl_t          f1_ctl_r;
  logic [39:0]   f1_p_r;
  logic [QW-1:0] f1_q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_ctl_r.vld <= 1'b0;
    end else if (en) begin
      f1_ctl_r <= st_ctl[ANGLE_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f1_p_r <= {st_cor[ANGLE_STEPS].z, 8'd0} - 40'(st_cor[ANGLE_STEPS].z);
      f1_q_r <= st_nq[ANGLE_STEPS];
    end
  end

  // Scale and round the tint, apply the saturation clamp.
  logic [TW-1:0] tsum;
  logic [FW-1:0] tval;
  logic [15:0]   tint_nxt, sat_nxt;

  always_comb begin
    tsum = {1'b0, f1_p_r, {OUT_FRAC_BITS{1'b0}}} + TW'({1'b1, 31'd0});
    tval = tsum[TW-1:32];
    if (f1_ctl_r.grey || (tval >= FW'(FULL))) begin
      tint_nxt = 16'd0;
    end else begin
      tint_nxt = sat16(32'(tval));
    end
    sat_nxt = f1_ctl_r.sat_full ? FULL16 : sat16(32'(f1_q_r));
  end

  logic        f2_vld_r, f2_last_r;
  logic [15:0] f2_int_r, f2_tint_r, f2_sat_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f2_vld_r <= 1'b0;
    end else if (en) begin
      f2_vld_r <= f1_ctl_r.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f2_last_r <= f1_ctl_r.last;
      f2_int_r  <= f1_ctl_r.intensity;
      f2_tint_r <= tint_nxt;
      f2_sat_r  <= sat_nxt;
    end
  end

  // Output register plus one skid entry; the pipeline holds while the skid is full.
  logic        out_last_r, skid_last_r;
  logic [15:0] out_int_r, out_tint_r, out_sat_r;
  logic [15:0] skid_int_r, skid_tint_r, skid_sat_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else if (skid_vld_r) begin
      if (out_res.ready) begin
        skid_vld_r <= 1'b0;
      end
    end else if (!out_vld_r || out_res.ready) begin
      out_vld_r <= f2_vld_r;
    end else if (f2_vld_r) begin
      skid_vld_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_vld_r) begin
      if (out_res.ready) begin
        out_last_r <= skid_last_r;
        out_int_r  <= skid_int_r;
        out_tint_r <= skid_tint_r;
        out_sat_r  <= skid_sat_r;
      end
    end else if (!out_vld_r || out_res.ready) begin
      out_last_r <= f2_last_r;
      out_int_r  <= f2_int_r;
      out_tint_r <= f2_tint_r;
      out_sat_r  <= f2_sat_r;
    end else begin
      skid_last_r <= f2_last_r;
      skid_int_r  <= f2_int_r;
      skid_tint_r <= f2_tint_r;
      skid_sat_r  <= f2_sat_r;
    end
  end

  assign out_res.valid      = out_vld_r;
  assign out_res.last_out   = out_last_r;
  assign out_res.intensity  = out_int_r;
  assign out_res.tint       = out_tint_r;
  assign out_res.saturation = out_sat_r;

  `RTITS_ASSERT_IMP(a_skid_behind_out, skid_vld_r, out_vld_r, "skid entry held with empty output register")
  `RTITS_ASSERT_NXT(a_skid_drains, skid_vld_r && out_res.ready, !skid_vld_r, "skid entry not drained")
  `RTITS_ASSERT_IMP(a_sat_range, out_vld_r, out_sat_r <= FULL16, "saturation above full scale")
  `RTITS_ASSERT_IMP(a_tint_range, out_vld_r, (out_tint_r < FULL16) || (FULL16 == 16'hFFFF), "tint not wrapped")

endmodule

`default_nettype wire

// File: hdl/rtits_step.sv
// ----------------------------------------------------------------------------
// rtits_step
// One pipeline stage: one vectoring rotation and, in the first stages, one
// quotient bit of the saturation divider.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rtits_step
  import rtits_pkg::*;
#(
  parameter int OUT_FRAC_BITS = OUT_FRAC_BITS_DEF,
  parameter int STEP          = 0
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       en,
  input  ctl_t                       ctl_i,
  input  cor_t                       cor_i,
  input  logic [10:0]                rem_i,
  input  logic [OUT_FRAC_BITS+7:0]   nq_i,
  input  logic [10:0]                dvs_i,
  output ctl_t                       ctl_o,
  output cor_t                       cor_o,
  output logic [10:0]                rem_o,
  output logic [OUT_FRAC_BITS+7:0]   nq_o,
  output logic [10:0]                dvs_o
);

  localparam int QW = OUT_FRAC_BITS + 8;
  localparam logic [31:0] ANG = ATAN_TURNS[STEP];

  ctl_t            ctl_r;
  cor_t            cor_r, cor_nxt;
  logic [10:0]     rem_r, rem_nxt;
  logic [QW-1:0]   nq_r, nq_nxt;
  logic [10:0]     dvs_r;

  logic signed [CW-1:0] dx, dy;
  logic [11:0]          trial;
  logic                 ge;

  always_comb begin
    dx = $signed(cor_i.y) >>> STEP;
    dy = $signed(cor_i.x) >>> STEP;
    cor_nxt = cor_i;
    if (!cor_i.y[CW-1]) begin
      cor_nxt.x = cor_i.x + dx;
      cor_nxt.y = cor_i.y - dy;
      cor_nxt.z = cor_i.z + ANG;
    end else begin
      cor_nxt.x = cor_i.x - dx;
      cor_nxt.y = cor_i.y + dy;
      cor_nxt.z = cor_i.z - ANG;
    end

    // Restoring division, one quotient bit shifted in per stage for the first QW stages.
    trial = {rem_i, nq_i[QW-1]};
    ge    = trial >= {1'b0, dvs_i};
    if (STEP < QW) begin
      rem_nxt = ge ? 11'(trial - {1'b0, dvs_i}) : trial[10:0];
      nq_nxt  = {nq_i[QW-2:0], ge};
    end else begin
      rem_nxt = rem_i;
      nq_nxt  = nq_i;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r.vld <= 1'b0;
    end else if (en) begin
      ctl_r <= ctl_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cor_r <= cor_nxt;
      rem_r <= rem_nxt;
      nq_r  <= nq_nxt;
      dvs_r <= dvs_i;
    end
  end

  assign ctl_o = ctl_r;
  assign cor_o = cor_r;
  assign rem_o = rem_r;
  assign nq_o  = nq_r;
  assign dvs_o = dvs_r;

endmodule

`default_nettype wire

// File: tb/tb_rgb_to_intensity_tint_saturation_core.sv
// ----------------------------------------------------------------------------
// tb_rgb_to_intensity_tint_saturation_core
// Streams RGB pixels through the converter and checks each intensity, tint
// and saturation result against a bit-exact model: a directed table first,
// then random pixels under several idle and stall mixes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_rgb_to_intensity_tint_saturation_core;

  localparam int          FRAC       = 8;
  localparam longint      TURN       = 64'sd4294967296;
  localparam longint      ROOT3      = 64'sd7439101574;
  localparam int          CYCLE_CAP  = 200000;
  localparam int          DRAIN_WAIT = 60;
  localparam int          PHASE_PIX  = 350;

  typedef struct packed {
    logic [15:0] intensity;
    logic [15:0] tint;
    logic [15:0] saturation;
    logic        last;
  } hsi_t;

  typedef struct packed {
    logic [7:0]  r;
    logic [7:0]  g;
    logic [7:0]  b;
    logic        last;
    logic        typed;
    logic [15:0] ei;
    logic [15:0] et;
    logic [15:0] es;
  } pix_row_t;

  localparam int NROWS = 18;
  // Rows with typed set carry results that follow directly from the formulas.
  localparam pix_row_t DIRECTED [NROWS] = '{
    '{8'd0,   8'd0,   8'd0,   1'b0, 1'b1, 16'd0,     16'd0, 16'd0},
    '{8'd255, 8'd255, 8'd255, 1'b1, 1'b1, 16'd65280, 16'd0, 16'd65280},
    '{8'd128, 8'd128, 8'd128, 1'b0, 1'b1, 16'd32768, 16'd0, 16'd0},
    '{8'd1,   8'd1,   8'd1,   1'b1, 1'b1, 16'd256,   16'd0, 16'd0},
    '{8'd255, 8'd0,   8'd0,   1'b0, 1'b0, 16'd0, 16'd0, 16'd0},
    '{8'd0,   8'd255, 8'd0,   1'b1, 1'b0, 16'd0, 16'd0, 16'd0},
    '{8'd0,   8'd0,   8'd255, 1'b0, 1'b0, 16'd0, 16'd0, 16'd0},
    '{8'd255, 8'd255, 8'd0,   1'b1, 1'b0, 16'd0, 16'd0, 16'd0},
    '{8'd0,   8'd255, 8'd255, 1'b0, 1'b0, 16'd0, 16'd0, 16'd0},
    '{8'd255, 8'd0,   8'd255, 1'b1, 1'b0, 16'd0, 16'd0, 16'd0},
    '{8'd255, 8'd254, 8'd254, 1'b0, 1'b0, 16'd0, 16'd0, 16'd0},
    '{8'd255, 8'd0,   8'd1,   1'b1, 1'b0, 16'd0, 16'd0, 16'd0},
    '{8'd254, 8'd0,   8'd1,   1'b0, 1'b0, 16'd0, 16'd0, 16'd0},
    '{8'd1,   8'd0,   8'd0,   1'b1, 1'b0, 16'd0, 16'd0, 16'd0},
    '{8'd0,   8'd1,   8'd0,   1'b0, 1'b0, 16'd0, 16'd0, 16'd0},
    '{8'd0,   8'd0,   8'd1,   1'b1, 1'b0, 16'd0, 16'd0, 16'd0},
    '{8'd200, 8'd100, 8'd50,  1'b0, 1'b0, 16'd0, 16'd0, 16'd0},
    '{8'd254, 8'd255, 8'd254, 1'b1, 1'b0, 16'd0, 16'd0, 16'd0}
  };

  localparam logic [31:0] ARC_TURNS [30] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
    32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
    32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001
  };

  logic clk;
  logic rst_n;
  int   idle_pct;
  int   stall_pct;
  int   errors;
  int   cycles;
  logic typed_pending;
  hsi_t typed_result;

  hsi_t        pending_hsi [$];
  logic        pending_typed [$];

  rtits_pix_if pix ();
  rtits_res_if res ();

  rgb_to_intensity_tint_saturation_core dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_pix  (pix),
    .out_res (res)
  );

  function automatic logic [63:0] rdiv(input logic [63:0] num, input logic [63:0] den);
    return (2 * num + den) / (2 * den);
  endfunction

  function automatic logic [63:0] chan_sat(input int c, input int sum, input logic [63:0] full);
    logic [63:0] q;
    if (3 * c < sum) begin
      q = rdiv(64'(sum - 3 * c) * full, 64'(sum));
    end else begin
      if (sum == 765) return full;
      q = rdiv(64'(3 * c - sum) * full, 64'(765 - sum));
    end
    return (q > full) ? full : q;
  endfunction

  function automatic logic [63:0] hue_turn(input int r, input int g, input int b,
                                           input logic [63:0] full);
    longint      x;
    longint      y;
    longint      z;
    longint      dx;
    longint      dy;
    logic [63:0] zu;
    logic [63:0] t;
    if (r == g && g == b) return 0;
    x = longint'(2 * r - g - b) * TURN;
    y = longint'(g - b) * ROOT3;
    z = 0;
    if (x < 0) begin
      x = -x;
      y = -y;
      z = TURN / 2;
    end
    for (int i = 0; i < 30; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x = x + dx;
        y = y - dy;
        z = z + longint'(ARC_TURNS[i]);
      end else begin
        x = x - dx;
        y = y + dy;
        z = z - longint'(ARC_TURNS[i]);
      end
    end
    zu = 64'(z) & 64'hFFFF_FFFF;
    t  = (zu * full * 2 + 64'(TURN)) >> 33;
    return (t >= full) ? 64'd0 : t;
  endfunction

  function automatic logic [15:0] clip16(input logic [63:0] v);
    return (v > 64'd65535) ? 16'hFFFF : v[15:0];
  endfunction

  function automatic hsi_t predict_hsi(input logic [7:0] r, input logic [7:0] g,
                                       input logic [7:0] b, input logic last);
    hsi_t        h;
    int          sum;
    logic [63:0] full;
    logic [63:0] sat;
    logic [63:0] s;
    sum  = int'(r) + int'(g) + int'(b);
    full = 64'd255 << FRAC;
    sat  = chan_sat(int'(r), sum, full);
    s    = chan_sat(int'(g), sum, full);
    if (s > sat) sat = s;
    s    = chan_sat(int'(b), sum, full);
    if (s > sat) sat = s;
    h.intensity  = clip16(rdiv(64'(sum) << FRAC, 64'd3));
    h.tint       = clip16(hue_turn(int'(r), int'(g), int'(b), full));
    h.saturation = clip16(sat);
    h.last       = last;
    return h;
  endfunction

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Input beats are turned into expectations and output beats are checked in
  // one process, so both see the same sampled values at each rising edge.
  always @(posedge clk) begin
    hsi_t want;
    hsi_t got;
    logic was_typed;
    cycles <= cycles + 1;
    if (rst_n && pix.valid && pix.ready) begin
      pending_hsi.push_back(predict_hsi(pix.red, pix.green, pix.blue, pix.last_pixel));
      pending_typed.push_back(typed_pending);
    end
    if (rst_n && res.valid && res.ready) begin
      got = '{res.intensity, res.tint, res.saturation, res.last_out};
      if (pending_hsi.size() == 0) begin
        $display("%0t: unexpected result beat %h", $time, got);
        errors++;
      end else begin
        want      = pending_hsi.pop_front();
        was_typed = pending_typed.pop_front();
        if (was_typed && want != typed_result) begin
          $display("%0t: predictor disagrees with table: expected %h, actual %h",
                   $time, typed_result, want);
          errors++;
        end
        if (got.intensity != want.intensity) begin
          $display("%0t: intensity expected %0d, actual %0d", $time,
                   want.intensity, got.intensity);
          errors++;
        end
        if (got.tint != want.tint) begin
          $display("%0t: tint expected %0d, actual %0d", $time, want.tint, got.tint);
          errors++;
        end
        if (got.saturation != want.saturation) begin
          $display("%0t: saturation expected %0d, actual %0d", $time,
                   want.saturation, got.saturation);
          errors++;
        end
        if (got.last != want.last) begin
          $display("%0t: last expected %0b, actual %0b", $time, want.last, got.last);
          errors++;
        end
      end
    end
    if (cycles > CYCLE_CAP) begin
      $display("rgb_to_intensity_tint_saturation_core: mismatch");
      $finish;
    end
  end

  always @(negedge clk) begin
    if (!rst_n) res.ready <= 1'b0;
    else        res.ready <= ($urandom_range(99) >= stall_pct);
  end

  // The beat stays on the bus after it is taken; the next call or a drain
  // replaces or withdraws it at the same falling edge.
  task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
                            input logic last);
    while ($urandom_range(99) < idle_pct) begin
      pix.valid <= 1'b0;
      @(negedge clk);
    end
    pix.valid      <= 1'b1;
    pix.red        <= r;
    pix.green      <= g;
    pix.blue       <= b;
    pix.last_pixel <= last;
    @(posedge clk);
    while (!pix.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    pix.valid <= 1'b0;
    while (pending_hsi.size() != 0) @(negedge clk);
  endtask

  task automatic random_pixel();
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    int         kind;
    r    = 8'($urandom);
    g    = 8'($urandom);
    b    = 8'($urandom);
    kind = $urandom_range(9);
    // Some pixels are grey, near grey, or built from the channel extremes.
    if (kind == 0) begin
      g = r;
      b = r;
    end else if (kind == 1) begin
      g = r + 8'($urandom_range(2)) - 8'd1;
      b = r;
    end else if (kind == 2) begin
      r = {8{r[0]}};
      g = {8{g[0]}};
      b = {8{b[0]}};
    end
    send_pixel(r, g, b, 1'($urandom));
  endtask

  initial begin
    errors        = 0;
    cycles        = 0;
    idle_pct      = 0;
    stall_pct     = 0;
    typed_pending = 1'b0;
    typed_result  = '0;
    rst_n          = 1'b0;
    pix.valid      = 1'b0;
    pix.red        = '0;
    pix.green      = '0;
    pix.blue       = '0;
    pix.last_pixel = 1'b0;
    res.ready      = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Typed rows go one at a time so the expectation matches its own row.
    foreach (DIRECTED[i]) begin
      typed_pending = DIRECTED[i].typed;
      typed_result  = '{DIRECTED[i].ei, DIRECTED[i].et, DIRECTED[i].es, DIRECTED[i].last};
      send_pixel(DIRECTED[i].r, DIRECTED[i].g, DIRECTED[i].b, DIRECTED[i].last);
      if (DIRECTED[i].typed) wait_drained();
    end
    wait_drained();
    typed_pending = 1'b0;

    for (int ph = 0; ph < 4; ph++) begin
      idle_pct  = (ph == 1 || ph == 3) ? ((ph == 1) ? 53 : 26) : 0;
      stall_pct = (ph == 2 || ph == 3) ? ((ph == 2) ? 53 : 26) : 0;
      for (int n = 0; n < PHASE_PIX; n++) random_pixel();
    end
    idle_pct = 0;

    wait_drained();
    repeat (DRAIN_WAIT) @(negedge clk);
    if (errors == 0) begin
      $display("rgb_to_intensity_tint_saturation_core: match");
    end else begin
      $display("rgb_to_intensity_tint_saturation_core: mismatch");
    end
    $finish;
  end

endmodule
